// ===== hdl/srd_pkg.sv =====
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants of the sprite RLE row decoder.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int MODE_W      = 2;
    localparam int WIDTH_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int FILL_W      = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCOUNT_W    = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH   = 1'd1;

    // format modes (code 3 decodes as packed)
    localparam logic [MODE_W-1:0] MODE_PLAIN    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TYPE_LEN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PACKED   = 2'd2;

    localparam logic [MODE_W-1:0]  FORMAT_MODE_RESET = MODE_TYPE_LEN;
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET   = 16'd1;

    localparam logic [BYTE_W-1:0] RAW_TYPE = 8'hFF;
    localparam logic [2:0]        RAW_CODE = 3'd7;
    localparam logic [FILL_W-1:0] FILL_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [MODE_W-1:0]  format_mode;
        logic [WIDTH_W-1:0] row_width;
    } srd_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  pixel_index;
        logic [COUNT_W-1:0] repeat_count;
        logic               from_raw;
        logic               end_of_row;
    } srd_result_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } srd_qstat_t;

endpackage

// ===== hdl/srd_byte_if.sv =====
// ----------------------------------------------------------------------------
// srd_byte_if
// Input channel: one byte of sprite row data per transaction.
// ----------------------------------------------------------------------------
interface srd_byte_if;
    import srd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);
endinterface

// ===== hdl/srd_pixel_if.sv =====
// ----------------------------------------------------------------------------
// srd_pixel_if
// Output channel: one pixel run or raw pixel per transaction.
// ----------------------------------------------------------------------------
interface srd_pixel_if;
    import srd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  pixel_index;
    logic [COUNT_W-1:0] repeat_count;
    logic               from_raw;
    logic               end_of_row;

    modport source (output valid, output pixel_index, output repeat_count,
                    output from_raw, output end_of_row, input ready);
    modport sink   (input valid, input pixel_index, input repeat_count,
                    input from_raw, input end_of_row, output ready);
endinterface

// ===== hdl/srd_front.sv =====
// ----------------------------------------------------------------------------
// srd_front
// Header parser and row pixel counter. Takes one byte per cycle unless the
// queue is full and pushes each pixel run it produces into the queue.
// ----------------------------------------------------------------------------
module srd_front (
    input  logic                clk,
    input  logic                rst_n,
    srd_byte_if.sink            bytes,
    input  srd_pkg::srd_cfg_t   cfg,
    input  logic                q_full,
    output logic                push,
    output srd_pkg::srd_result_t result
);
    import srd_pkg::*;

    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_RAW = 2'd2;

    logic [1:0]         phase_reg,    phase_next;
    logic [BYTE_W-1:0]  pending_reg,  pending_next;
    logic [COUNT_W-1:0] raw_left_reg, raw_left_next;
    logic [FILL_W-1:0]  filled_reg,   filled_next;

    logic               accept;
    logic               has_res;
    logic [BYTE_W-1:0]  res_pix;
    logic [COUNT_W-1:0] res_cnt;
    logic               res_raw;
    logic               res_eor;
    logic [BYTE_W-1:0]  b;
    logic [COUNT_W-1:0] byte_len;
    logic [COUNT_W-1:0] packed_len;
    logic [FILL_W:0]    sum;
    logic [FILL_W-1:0]  sat;

    assign bytes.ready = !q_full;
    assign accept      = bytes.valid && bytes.ready;
    assign b           = bytes.byte_value;
    assign byte_len    = {1'b0, b} + 9'd1;
    assign packed_len  = {4'b0, b[4:0]} + 9'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        raw_left_next = raw_left_reg;
        filled_next   = filled_reg;
        has_res       = 1'b0;
        res_pix       = b;
        res_cnt       = 9'd1;
        res_raw       = 1'b1;

        case (phase_reg)
            PH_RAW:
            begin
                if (raw_left_reg <= 9'd1)
                begin
                    raw_left_next = '0;
                    phase_next    = PH_HDR;
                end
                else
                begin
                    raw_left_next = raw_left_reg - 9'd1;
                end
                has_res = 1'b1;
            end
            PH_LEN:
            begin
                if (pending_reg == RAW_TYPE)
                begin
                    raw_left_next = byte_len;
                    phase_next    = PH_RAW;
                end
                else
                begin
                    phase_next = PH_HDR;
                    has_res    = 1'b1;
                    res_pix    = pending_reg;
                    res_cnt    = byte_len;
                    res_raw    = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_HDR;
                case (cfg.format_mode)
                    MODE_PLAIN:
                    begin
                        has_res = 1'b1;
                    end
                    MODE_TYPE_LEN:
                    begin
                        pending_next = b;
                        phase_next   = PH_LEN;
                    end
                    default:
                    begin
                        // packed header: code in the top three bits
                        if (b[7:5] == RAW_CODE)
                        begin
                            raw_left_next = packed_len;
                            phase_next    = PH_RAW;
                        end
                        else
                        begin
                            has_res = 1'b1;
                            res_pix = {5'b0, b[7:5]};
                            res_cnt = packed_len;
                            res_raw = 1'b0;
                        end
                    end
                endcase
            end
        endcase

        // saturate the pixel count, then check for the row end
        sum     = {1'b0, filled_reg} + {9'b0, res_cnt};
        sat     = (sum > {1'b0, FILL_MAX}) ? FILL_MAX : sum[FILL_W-1:0];
        res_eor = (sat >= {1'b0, cfg.row_width});

        if (has_res)
        begin
            filled_next = sat;
            if (res_eor)
            begin
                filled_next   = '0;
                phase_next    = PH_HDR;
                pending_next  = '0;
                raw_left_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR;
            pending_reg  <= '0;
            raw_left_reg <= '0;
            filled_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
            raw_left_reg <= raw_left_next;
            filled_reg   <= filled_next;
        end
    end

    assign push                = accept && has_res;
    assign result.pixel_index  = res_pix;
    assign result.repeat_count = res_cnt;
    assign result.from_raw     = res_raw;
    assign result.end_of_row   = res_eor;

endmodule

// ===== hdl/srd_queue.sv =====
// ----------------------------------------------------------------------------
// srd_queue
// Two-entry result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module srd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srd_pkg::srd_result_t push_data,
    input  logic                 pop,
    output srd_pkg::srd_result_t pop_data,
    output srd_pkg::srd_qstat_t  stat
);
    import srd_pkg::*;

    srd_result_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg;
    logic [QCOUNT_W-1:0] count_next;

    assign stat.full      = (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/srd_back.sv =====
// ----------------------------------------------------------------------------
// srd_back
// Output register stage. Pulls results from the queue and holds each one on
// the pixel channel until the transaction completes.
// ----------------------------------------------------------------------------
module srd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  srd_pkg::srd_result_t q_data,
    output logic                 pop,
    srd_pixel_if.source          pixels
);
    import srd_pkg::*;

    logic        valid_reg;
    srd_result_t data_reg;
    logic        free;

    assign free = !valid_reg || pixels.ready;
    assign pop  = free && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= q_data;
    end

    assign pixels.valid        = valid_reg;
    assign pixels.pixel_index  = data_reg.pixel_index;
    assign pixels.repeat_count = data_reg.repeat_count;
    assign pixels.from_raw     = data_reg.from_raw;
    assign pixels.end_of_row   = data_reg.end_of_row;

endmodule

// ===== hdl/sprite_rle_row_decoder.sv =====
// ----------------------------------------------------------------------------
// sprite_rle_row_decoder
// Run-length decoder for indexed-color sprite rows.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle on the byte channel while the queue is not
// full and emits pixel runs on the pixel channel; a type byte, a raw length
// byte and a packed raw header give no result. Parser and row counter update
// on each accepted byte; results pass through a two-entry queue and then an
// output register, and the byte channel stalls only once both queue entries
// and the output register hold results. The user must write format_mode and
// row_width over the cfg port only while the block is idle; the block itself
// does not enforce this.
module sprite_rle_row_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [srd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srd_pkg::CFG_DATA_W-1:0]    cfg_data,
    srd_byte_if.sink                          bytes,
    srd_pixel_if.source                       pixels
);
    import srd_pkg::*;

    logic [MODE_W-1:0]  format_mode_reg;
    logic [WIDTH_W-1:0] row_width_reg;
    srd_cfg_t           cfg;
    logic               q_push;
    logic               q_pop;
    srd_result_t        q_in;
    srd_result_t        q_out;
    srd_qstat_t         q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= FORMAT_MODE_RESET;
            row_width_reg   <= ROW_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT_MODE: format_mode_reg <= cfg_data[MODE_W-1:0];
                REG_ROW_WIDTH:   row_width_reg   <= cfg_data[WIDTH_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.format_mode = format_mode_reg;
    assign cfg.row_width   = row_width_reg;

    srd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .cfg    (cfg),
        .q_full (q_stat.full),
        .push   (q_push),
        .result (q_in)
    );

    srd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    srd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_stat.not_empty),
        .q_data      (q_out),
        .pop         (q_pop),
        .pixels      (pixels)
    );

    // never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("result pushed into a full queue");

    // never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_stat.not_empty)
        else $error("result popped from an empty queue");

    // a popped result shows up on the pixel channel next cycle
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> pixels.valid)
        else $error("popped result not presented on the pixel channel");

endmodule
